// File: sv/sva_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the smoothed velocity/acceleration unit.
package sva_pkg;

    // Fixed-point format of positions, speeds and time stamps
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;
    localparam int STAMP_W   = 32;

    // Blend weights: Q1.16, one is 2^16
    localparam int WEIGHT_W     = 17;
    localparam int WEIGHT_SHIFT = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_SHIFT);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(1 << (WEIGHT_SHIFT - 1));

    // Blend accumulator: 18-bit signed weight times 32-bit signed operand
    localparam int MIX_ACC_W = WEIGHT_W + 1 + POS_W;
    localparam int MIX_Q_W   = MIX_ACC_W - WEIGHT_SHIFT;

    // Divider: quotient bits retired per cycle
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = POS_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Axes and warm-up level
    localparam int AXES    = 3;
    localparam int AXIS_W  = $clog2(AXES);
    localparam int LEVEL_W = 2;
    localparam logic [LEVEL_W-1:0] WARM_MAX = LEVEL_W'(2);

    // Saturation limits
    localparam logic signed [POS_W-1:0] SAT_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] SAT_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KEEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_KEEP = CFG_IDX_W'(1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_MIX,
        ST_MIX_WAIT,
        ST_NEXT,
        ST_DONE
    } seq_state_t;

    // Which quantity the current step updates
    typedef enum logic {
        PH_SPEED,
        PH_ACCEL
    } phase_t;

    // Blend unit multiply steps
    typedef enum logic [1:0] {
        MIX_IDLE,
        MIX_OLD,
        MIX_NEW
    } mix_step_t;

    // Status of a shared arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: sv/sva_div.sv
`timescale 1ns / 1ps
// Iterative rate unit: (diff << FRAC_BITS) / dt, truncated and saturated to 32 bits.
module sva_div
    import sva_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [POS_W:0]    diff,
    input  logic [STAMP_W-1:0]       divisor,
    output logic signed [POS_W-1:0]  result,
    output unit_stat_t               stat
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   neg_reg;
    logic                   ovf_reg;
    logic [STAMP_W-1:0]     dt_reg;
    logic [POS_W-1:0]       rem_reg;
    logic [POS_W-1:0]       quo_reg;

    logic [POS_W:0]         mag_full;
    logic [POS_W-1:0]       mag;
    logic [POS_W-1:0]       hi_part;
    logic [POS_W-1:0]       lo_part;
    logic [POS_W-1:0]       rem_next;
    logic [POS_W-1:0]       quo_next;

    // Magnitude of the numerator, split into the part above and below 2^32
    always_comb
    begin
        mag_full = diff[POS_W] ? (~diff + 1'b1) : diff;
        mag      = mag_full[POS_W-1:0];
        hi_part  = {{(POS_W-FRAC_BITS){1'b0}}, mag[POS_W-1:POS_W-FRAC_BITS]};
        lo_part  = {mag[POS_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    end

    // DIV_STEP restoring steps per cycle
    always_comb
    begin
        logic [POS_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            trial = {rem_next, quo_next[POS_W-1]};
            if (trial >= {1'b0, dt_reg})
            begin
                trial    = trial - {1'b0, dt_reg};
                quo_next = {quo_next[POS_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_next[POS_W-2:0], 1'b0};
            end
            rem_next = trial[POS_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= diff[POS_W];
            ovf_reg <= (hi_part >= divisor);
            dt_reg  <= divisor;
            rem_reg <= hi_part;
            quo_reg <= lo_part;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Sign and saturation
    always_comb
    begin
        if (!neg_reg)
        begin
            result = (ovf_reg || quo_reg[POS_W-1]) ? SAT_MAX : quo_reg;
        end
        else
        begin
            result = (ovf_reg || (quo_reg[POS_W-1] && (|quo_reg[POS_W-2:0])))
                     ? SAT_MIN : (~quo_reg + 1'b1);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: sv/sva_mix.sv
`timescale 1ns / 1ps
// Blend unit: floor((w*old + (1-w)*fresh) / 2^16) on one shared multiplier.
module sva_mix
    import sva_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [WEIGHT_W-1:0]      weight,
    input  logic signed [POS_W-1:0]  old_val,
    input  logic signed [POS_W-1:0]  fresh_val,
    output logic signed [POS_W-1:0]  result,
    output unit_stat_t               stat
);

    mix_step_t                      step_reg;
    mix_step_t                      step_next;
    logic                           done_reg;
    logic [WEIGHT_W-1:0]            w_reg;
    logic signed [POS_W-1:0]        old_reg;
    logic signed [POS_W-1:0]        fresh_reg;
    logic signed [MIX_ACC_W-1:0]    acc_reg;

    logic [WEIGHT_W-1:0]            w_clamp;
    logic signed [WEIGHT_W:0]       mul_a;
    logic signed [POS_W-1:0]        mul_b;
    logic signed [MIX_ACC_W-1:0]    prod;
    logic signed [MIX_Q_W-1:0]      q;

    // Weights above one act as one
    assign w_clamp = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;

    // Shared multiplier: old term first, then fresh term
    always_comb
    begin
        if (step_reg == MIX_OLD)
        begin
            mul_a = {1'b0, w_reg};
            mul_b = old_reg;
        end
        else
        begin
            mul_a = {1'b0, WEIGHT_ONE - w_reg};
            mul_b = fresh_reg;
        end
    end

    assign prod = MIX_ACC_W'(mul_a) * MIX_ACC_W'(mul_b);

    always_comb
    begin
        case (step_reg)
            MIX_IDLE: step_next = start ? MIX_OLD : MIX_IDLE;
            MIX_OLD:  step_next = MIX_NEW;
            MIX_NEW:  step_next = MIX_IDLE;
            default:  step_next = MIX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MIX_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == MIX_NEW);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && step_reg == MIX_IDLE)
        begin
            w_reg     <= w_clamp;
            old_reg   <= old_val;
            fresh_reg <= fresh_val;
        end
        if (step_reg == MIX_OLD)
        begin
            acc_reg <= prod;
        end
        else if (step_reg == MIX_NEW)
        begin
            acc_reg <= acc_reg + prod;
        end
    end

    // Arithmetic shift is the floor; then saturate
    assign q = acc_reg[MIX_ACC_W-1:WEIGHT_SHIFT];

    always_comb
    begin
        if (q[MIX_Q_W-1:POS_W-1] == '0 || q[MIX_Q_W-1:POS_W-1] == '1)
        begin
            result = q[POS_W-1:0];
        end
        else
        begin
            result = q[MIX_Q_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    assign stat.busy = (step_reg != MIX_IDLE);
    assign stat.done = done_reg;

endmodule

// File: sv/smoothed_velocity_acceleration_unit.sv
`timescale 1ns / 1ps
// A dropped word (repeated stamp) is taken without leaving idle; a first sample goes
// straight to the output register; otherwise each word runs one rate-and-blend step per axis
// (divider, then blend) at warm level 1 and two per axis (speed, then accel) at warm level 2.
// One word in flight; in_ready is high whenever the sequencer is idle, also while a
// result waits in the output register. Reset (rst_n, async) clears control and tracker
// state to zero and sets both keep weights to one half; payload registers are not reset.
module smoothed_velocity_acceleration_unit
    import sva_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [POS_W-1:0]     pos_x,
    input  logic signed [POS_W-1:0]     pos_y,
    input  logic signed [POS_W-1:0]     pos_z,
    input  logic [STAMP_W-1:0]          stamp,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [POS_W-1:0]     vel_x,
    output logic signed [POS_W-1:0]     vel_y,
    output logic signed [POS_W-1:0]     vel_z,
    output logic signed [POS_W-1:0]     acc_x,
    output logic signed [POS_W-1:0]     acc_y,
    output logic signed [POS_W-1:0]     acc_z,
    output logic [LEVEL_W-1:0]          warm_level,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WEIGHT_W-1:0]         cfg_data
);

    // Sequencer
    seq_state_t                 state_reg;
    seq_state_t                 state_next;
    logic [AXIS_W-1:0]          axis_reg;
    logic [AXIS_W-1:0]          axis_next;
    phase_t                     phase_reg;
    phase_t                     phase_next;

    // Configuration
    logic [WEIGHT_W-1:0]        spd_w_reg;
    logic [WEIGHT_W-1:0]        acc_w_reg;

    // Tracker state
    logic signed [POS_W-1:0]    prev_pos_reg [AXES];
    logic signed [POS_W-1:0]    speed_avg_reg [AXES];
    logic signed [POS_W-1:0]    prev_speed_reg [AXES];
    logic signed [POS_W-1:0]    accel_avg_reg [AXES];
    logic [STAMP_W-1:0]         prev_stamp_reg;
    logic [LEVEL_W-1:0]         warm_count_reg;

    // Captured word
    logic signed [POS_W-1:0]    pos_in_reg [AXES];
    logic [STAMP_W-1:0]         stamp_in_reg;
    logic [STAMP_W-1:0]         dt_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [POS_W-1:0]    vel_out_reg [AXES];
    logic signed [POS_W-1:0]    acc_out_reg [AXES];
    logic [LEVEL_W-1:0]         level_out_reg;

    // Control strobes
    logic                       in_fire;
    logic                       out_fire;
    logic [STAMP_W-1:0]         dt_in;
    logic                       drop;
    logic                       div_start;
    logic                       mix_start;
    logic                       spd_wr;
    logic                       acc_wr;
    logic                       commit;

    // Shared units
    logic signed [POS_W-1:0]    op_a;
    logic signed [POS_W-1:0]    op_b;
    logic signed [POS_W:0]      div_diff;
    logic signed [POS_W-1:0]    div_result;
    unit_stat_t                 div_stat;
    logic [WEIGHT_W-1:0]        mix_weight;
    logic signed [POS_W-1:0]    mix_old;
    logic signed [POS_W-1:0]    mix_result;
    unit_stat_t                 mix_stat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign cfg_ready = 1'b1;

    // Repeated stamp check
    assign dt_in = stamp - prev_stamp_reg;
    assign drop  = (dt_in == '0);

    // Operand selection for the current axis and phase
    always_comb
    begin
        if (phase_reg == PH_SPEED)
        begin
            op_a       = pos_in_reg[axis_reg];
            op_b       = prev_pos_reg[axis_reg];
            mix_weight = spd_w_reg;
            mix_old    = speed_avg_reg[axis_reg];
        end
        else
        begin
            op_a       = speed_avg_reg[axis_reg];
            op_b       = prev_speed_reg[axis_reg];
            mix_weight = acc_w_reg;
            mix_old    = accel_avg_reg[axis_reg];
        end
        div_diff = {op_a[POS_W-1], op_a} - {op_b[POS_W-1], op_b};
    end

    sva_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .diff    (div_diff),
        .divisor (dt_reg),
        .result  (div_result),
        .stat    (div_stat)
    );

    sva_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mix_start),
        .weight    (mix_weight),
        .old_val   (mix_old),
        .fresh_val (div_result),
        .result    (mix_result),
        .stat      (mix_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !drop)
                begin
                    state_next = (warm_count_reg == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: state_next = div_stat.done ? ST_MIX : ST_DIV_WAIT;
            ST_MIX:      state_next = ST_MIX_WAIT;
            ST_MIX_WAIT: state_next = mix_stat.done ? ST_NEXT : ST_MIX_WAIT;
            ST_NEXT:
            begin
                if (phase_reg == PH_SPEED && warm_count_reg == WARM_MAX)
                begin
                    state_next = ST_DIV;
                end
                else if (axis_reg == AXIS_W'(AXES - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DONE:     state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        axis_next  = axis_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        mix_start  = 1'b0;
        spd_wr     = 1'b0;
        acc_wr     = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                axis_next  = '0;
                phase_next = PH_SPEED;
            end
            ST_DIV:      div_start = 1'b1;
            ST_DIV_WAIT: ;
            ST_MIX:      mix_start = 1'b1;
            ST_MIX_WAIT:
            begin
                spd_wr = mix_stat.done && (phase_reg == PH_SPEED);
                acc_wr = mix_stat.done && (phase_reg == PH_ACCEL);
            end
            ST_NEXT:
            begin
                if (phase_reg == PH_SPEED && warm_count_reg == WARM_MAX)
                begin
                    phase_next = PH_ACCEL;
                end
                else
                begin
                    phase_next = PH_SPEED;
                    if (axis_reg != AXIS_W'(AXES - 1))
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            ST_DONE:     commit = !out_valid_reg || out_ready;
            default:     ;
        endcase
    end

    // Control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= '0;
            phase_reg      <= PH_SPEED;
            spd_w_reg      <= WEIGHT_RST;
            acc_w_reg      <= WEIGHT_RST;
            prev_stamp_reg <= '0;
            warm_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                prev_pos_reg[i]   <= '0;
                speed_avg_reg[i]  <= '0;
                prev_speed_reg[i] <= '0;
                accel_avg_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;

            // Configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SPEED_KEEP: spd_w_reg <= cfg_data;
                    CFG_ACCEL_KEEP: acc_w_reg <= cfg_data;
                    default:        ;
                endcase
            end

            // Averages updated in place as each blend finishes
            if (spd_wr)
            begin
                speed_avg_reg[axis_reg] <= mix_result;
            end
            if (acc_wr)
            begin
                accel_avg_reg[axis_reg] <= mix_result;
            end

            // End of word: roll history forward
            if (commit)
            begin
                prev_stamp_reg <= stamp_in_reg;
                if (warm_count_reg != WARM_MAX)
                begin
                    warm_count_reg <= warm_count_reg + 1'b1;
                end
                for (int i = 0; i < AXES; i++)
                begin
                    prev_pos_reg[i]   <= pos_in_reg[i];
                    prev_speed_reg[i] <= speed_avg_reg[i];
                end
            end

            // Output valid
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_in_reg[0] <= pos_x;
            pos_in_reg[1] <= pos_y;
            pos_in_reg[2] <= pos_z;
            stamp_in_reg  <= stamp;
            dt_reg        <= dt_in;
        end
        if (commit)
        begin
            level_out_reg <= warm_count_reg;
            for (int i = 0; i < AXES; i++)
            begin
                vel_out_reg[i] <= speed_avg_reg[i];
                acc_out_reg[i] <= accel_avg_reg[i];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign vel_x      = vel_out_reg[0];
    assign vel_y      = vel_out_reg[1];
    assign vel_z      = vel_out_reg[2];
    assign acc_x      = acc_out_reg[0];
    assign acc_y      = acc_out_reg[1];
    assign acc_z      = acc_out_reg[2];
    assign warm_level = level_out_reg;

    // Checks
    a_warm_range: assert property (@(posedge clk) disable iff (!rst_n)
        warm_count_reg <= WARM_MAX)
        else $error("warm count out of range");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && stamp == prev_stamp_reg) |=> (state_reg == ST_IDLE && !$past(commit)))
        else $error("repeated stamp not dropped");

    a_first_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && stamp != prev_stamp_reg && warm_count_reg == '0) |=> state_reg == ST_DONE)
        else $error("first sample entered arithmetic steps");

endmodule
